FILE: hw/rtl/srbm_pkg.sv
`timescale 1ns / 1ps
package srbm_pkg;

    localparam logic [7:0] READ_FLAG = 8'h80;
    localparam logic [7:0] FULL_MASK = 8'hFF;
    localparam logic       BIT_ONE   = 1'b1;

    // operation codes as they arrive on the input item
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PUSH  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        logic       is_read;
        logic [5:0] reg_addr;
        logic [7:0] byte_count;
        logic [2:0] rx_align;
        logic [7:0] old_first;
        logic [7:0] write_byte;
        logic       miso;
    } t_in;

    typedef struct packed {
        logic       ss_n;
        logic       sck_pulse;
        logic       mosi;
        logic       read_valid;
        logic [7:0] read_data;
        logic [7:0] read_index;
        logic       need_write_data;
        logic       done_res;
    } t_out;

    // classified command handed from front to back
    typedef struct packed {
        t_op        op;
        logic       start_ok;
        logic       is_read;
        logic [7:0] addr_byte;
        logic [7:0] count;
        logic [7:0] mask;
        logic [7:0] old_first;
        logic [7:0] wr_byte;
        logic       miso;
    } t_cmd;

endpackage

FILE: hw/rtl/srbm_front.sv
`timescale 1ns / 1ps
module srbm_front (
    input  srbm_pkg::t_in  i_item,
    output srbm_pkg::t_cmd o_cmd
);

    always_comb begin
        o_cmd.op        = srbm_pkg::t_op'(i_item.operation);
        // a read of zero bytes never opens a burst
        o_cmd.start_ok  = !(i_item.is_read && (i_item.byte_count == 8'd0));
        o_cmd.is_read   = i_item.is_read;
        o_cmd.addr_byte = (i_item.is_read ? srbm_pkg::READ_FLAG : 8'h00)
                          | {1'b0, i_item.reg_addr, 1'b0};
        o_cmd.count     = i_item.byte_count;
        o_cmd.mask      = srbm_pkg::FULL_MASK << i_item.rx_align;
        o_cmd.old_first = i_item.old_first;
        o_cmd.wr_byte   = i_item.write_byte;
        o_cmd.miso      = i_item.miso;
    end

endmodule

FILE: hw/rtl/srbm_queue.sv
`timescale 1ns / 1ps
module srbm_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srbm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output srbm_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    srbm_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_wr, w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/srbm_back.sv
`timescale 1ns / 1ps
module srbm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  srbm_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output srbm_pkg::t_out o_data
);

    logic       r_active, r_read_mode, r_in_addr, r_loaded;
    logic [7:0] r_addr_byte, r_bytes_left, r_pos, r_out_shift, r_in_shift;
    logic [7:0] r_mask, r_kept;
    logic [2:0] r_bit_cnt;
    logic       r_valid;
    srbm_pkg::t_out r_data;

    logic       n_active, n_read_mode, n_in_addr, n_loaded;
    logic [7:0] n_addr_byte, n_bytes_left, n_pos, n_out_shift, n_in_shift;
    logic [7:0] n_mask, n_kept;
    logic [2:0] n_bit_cnt;
    srbm_pkg::t_out n_data;

    logic [7:0] w_bl_dec;

    // the output slot frees when it is empty or being taken
    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign w_bl_dec = r_bytes_left - 8'd1;

    always_comb begin
        n_active     = r_active;
        n_read_mode  = r_read_mode;
        n_in_addr    = r_in_addr;
        n_loaded     = r_loaded;
        n_addr_byte  = r_addr_byte;
        n_bytes_left = r_bytes_left;
        n_pos        = r_pos;
        n_out_shift  = r_out_shift;
        n_in_shift   = r_in_shift;
        n_mask       = r_mask;
        n_kept       = r_kept;
        n_bit_cnt    = r_bit_cnt;
        n_data       = '0;

        case (i_cmd.op)
            srbm_pkg::OP_START: begin
                if (!r_active && i_cmd.start_ok) begin
                    n_active     = 1'b1;
                    n_read_mode  = i_cmd.is_read;
                    n_addr_byte  = i_cmd.addr_byte;
                    n_bytes_left = i_cmd.count;
                    n_pos        = 8'd0;
                    n_bit_cnt    = 3'd0;
                    n_out_shift  = i_cmd.addr_byte;
                    n_in_shift   = 8'd0;
                    n_mask       = i_cmd.mask;
                    n_kept       = i_cmd.old_first;
                    n_in_addr    = 1'b1;
                    n_loaded     = 1'b1;
                end
            end
            srbm_pkg::OP_PUSH: begin
                if (r_active && !r_read_mode && !r_loaded && !r_in_addr) begin
                    n_out_shift = i_cmd.wr_byte;
                    n_loaded    = 1'b1;
                    n_bit_cnt   = 3'd0;
                end
            end
            srbm_pkg::OP_TICK: begin
                if (r_active && r_loaded) begin
                    n_data.sck_pulse = 1'b1;
                    n_data.mosi      = r_out_shift[7];
                    n_in_shift  = {r_in_shift[6:0], i_cmd.miso & srbm_pkg::BIT_ONE};
                    n_out_shift = {r_out_shift[6:0], 1'b0};
                    n_bit_cnt   = r_bit_cnt + 3'd1;
                    if (r_bit_cnt == 3'd7) begin
                        if (r_in_addr) begin
                            n_in_addr = 1'b0;
                            if (r_read_mode) begin
                                n_out_shift = (r_bytes_left > 8'd1) ? r_addr_byte : 8'd0;
                                n_loaded    = 1'b1;
                            end else begin
                                n_loaded = 1'b0;
                                if (r_bytes_left == 8'd0) begin
                                    n_active        = 1'b0;
                                    n_data.done_res = 1'b1;
                                end
                            end
                        end else if (r_read_mode) begin
                            n_data.read_valid = 1'b1;
                            // first byte keeps the old bits below the alignment
                            n_data.read_data  = (r_pos == 8'd0)
                                ? ((r_kept & ~r_mask) | (n_in_shift & r_mask)) : n_in_shift;
                            n_data.read_index = r_pos;
                            n_pos        = r_pos + 8'd1;
                            n_bytes_left = w_bl_dec;
                            if (w_bl_dec == 8'd0) begin
                                n_active        = 1'b0;
                                n_loaded        = 1'b0;
                                n_data.done_res = 1'b1;
                            end else begin
                                n_out_shift = (w_bl_dec > 8'd1) ? r_addr_byte : 8'd0;
                                n_loaded    = 1'b1;
                            end
                        end else begin
                            n_pos        = r_pos + 8'd1;
                            n_bytes_left = w_bl_dec;
                            n_loaded     = 1'b0;
                            if (w_bl_dec == 8'd0) begin
                                n_active        = 1'b0;
                                n_data.done_res = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        n_data.ss_n            = !n_active;
        n_data.need_write_data = n_active && !n_read_mode && !n_loaded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_read_mode  <= 1'b0;
            r_in_addr    <= 1'b0;
            r_loaded     <= 1'b0;
            r_addr_byte  <= 8'd0;
            r_bytes_left <= 8'd0;
            r_pos        <= 8'd0;
            r_bit_cnt    <= 3'd0;
            r_out_shift  <= 8'd0;
            r_in_shift   <= 8'd0;
            r_mask       <= srbm_pkg::FULL_MASK;
            r_kept       <= 8'd0;
            r_valid      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active     <= n_active;
                r_read_mode  <= n_read_mode;
                r_in_addr    <= n_in_addr;
                r_loaded     <= n_loaded;
                r_addr_byte  <= n_addr_byte;
                r_bytes_left <= n_bytes_left;
                r_pos        <= n_pos;
                r_bit_cnt    <= n_bit_cnt;
                r_out_shift  <= n_out_shift;
                r_in_shift   <= n_in_shift;
                r_mask       <= n_mask;
                r_kept       <= n_kept;
                r_valid      <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: hw/rtl/spi_register_burst_master.sv
`timescale 1ns / 1ps
// each item passes through the queue, and its result is registered in the back part after any items queued ahead
// throughput: one item per cycle while the result channel is not stalled, set by the burst engine in the back part
// the queue of QUEUE_DEPTH entries takes items while the result register is stalled
// reset: i_rst_n low at a clock edge empties the queue, clears the result valid and ends any
// burst, alignment mask all ones
module spi_register_burst_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // item channel in
    input  logic            i_valid,
    output logic            o_stall,
    input  srbm_pkg::t_in   i_data,
    // result channel out
    output logic            o_valid,
    input  logic            i_stall,
    output srbm_pkg::t_out  o_data
);

    srbm_pkg::t_cmd w_front_cmd;
    srbm_pkg::t_cmd w_queue_cmd;
    logic           w_full, w_empty, w_pop;

    // front: decode the operation, build the address byte and first-byte mask
    srbm_front u_front (
        .i_item (i_data),
        .o_cmd  (w_front_cmd)
    );

    // input stalls only when the queue has no free entry
    assign o_stall = w_full;

    srbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_queue_cmd)
    );

    // back: burst state, shift registers and the registered result item
    srbm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_queue_cmd),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;

    // run limits
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 120;
    localparam int TAIL_CYCLES  = 20;

    // burst tracker: mirrors the master's state and holds the pin states it will show
    class burst_tracker;
        bit       active, read_mode, addr_phase, loaded;
        bit [7:0] addr_byte, left, pos, tx_sh, rx_sh, mask, keep;
        bit [2:0] nbits;
        srbm_pkg::t_out pin_states_q[$];
        int       errors, checked, live_items, bursts_done, bytes_read;

        function new();
            mask = srbm_pkg::FULL_MASK;
        endfunction

        function int pending();
            return pin_states_q.size();
        endfunction

        function bit wants_byte();
            return active && !read_mode && !loaded;
        endfunction

        // next outgoing byte of a read: address again, or zero for the last one
        function void load_read();
            tx_sh  = (left > 8'd1) ? addr_byte : 8'h00;
            loaded = 1'b1;
        endfunction

        // a write byte (or the address of a write) has gone out
        function bit write_byte_sent();
            loaded = 1'b0;
            if (left == 8'd0) begin
                active = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // accepted input item: advance the state, queue the pins it will show
        function void note_item(srbm_pkg::t_in it);
            srbm_pkg::t_out r;
            bit [7:0]       v;
            r = '0;
            case (it.operation)
                srbm_pkg::OP_START: begin
                    if (!active && !(it.is_read && it.byte_count == 8'd0)) begin
                        active     = 1'b1;
                        read_mode  = it.is_read;
                        addr_byte  = (it.is_read ? srbm_pkg::READ_FLAG : 8'h00)
                                     | {1'b0, it.reg_addr, 1'b0};
                        left       = it.byte_count;
                        pos        = 8'd0;
                        nbits      = 3'd0;
                        tx_sh      = addr_byte;
                        rx_sh      = 8'h00;
                        mask       = srbm_pkg::FULL_MASK << it.rx_align;
                        keep       = it.old_first;
                        addr_phase = 1'b1;
                        loaded     = 1'b1;
                        live_items++;
                    end
                end
                srbm_pkg::OP_PUSH: begin
                    if (active && !read_mode && !loaded && !addr_phase) begin
                        tx_sh  = it.write_byte;
                        loaded = 1'b1;
                        nbits  = 3'd0;
                        live_items++;
                    end
                end
                srbm_pkg::OP_TICK: begin
                    if (active && loaded) begin
                        live_items++;
                        r.sck_pulse = 1'b1;
                        r.mosi      = tx_sh[7];
                        rx_sh       = {rx_sh[6:0], it.miso};
                        tx_sh       = tx_sh << 1;
                        nbits       = nbits + 3'd1;
                        if (nbits == 3'd0) begin
                            if (addr_phase) begin
                                addr_phase = 1'b0;
                                if (read_mode) load_read();
                                else r.done_res = write_byte_sent();
                            end else if (read_mode) begin
                                v = rx_sh;
                                if (pos == 8'd0) v = (keep & ~mask) | (v & mask);
                                r.read_valid = 1'b1;
                                r.read_data  = v;
                                r.read_index = pos;
                                bytes_read++;
                                pos  = pos + 8'd1;
                                left = left - 8'd1;
                                if (left == 8'd0) begin
                                    active     = 1'b0;
                                    loaded     = 1'b0;
                                    r.done_res = 1'b1;
                                end else begin
                                    load_read();
                                end
                            end else begin
                                pos        = pos + 8'd1;
                                left       = left - 8'd1;
                                r.done_res = write_byte_sent();
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (r.done_res) bursts_done++;
            r.ss_n            = !active;
            r.need_write_data = wants_byte();
            pin_states_q.push_back(r);
        endfunction

        function string pins_text(srbm_pkg::t_out p);
            return $sformatf("ss_n=%b sck=%b mosi=%b rv=%b rd=%02h ri=%0d need=%b done=%b",
                p.ss_n, p.sck_pulse, p.mosi, p.read_valid, p.read_data, p.read_index,
                p.need_write_data, p.done_res);
        endfunction

        // accepted result: compare with the oldest queued pin state
        function void check_pins(srbm_pkg::t_out got);
            srbm_pkg::t_out want;
            if (pin_states_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with nothing outstanding: %s", pins_text(got));
                return;
            end
            want = pin_states_q.pop_front();
            checked++;
            if (got.ss_n !== want.ss_n || got.sck_pulse !== want.sck_pulse ||
                got.mosi !== want.mosi || got.read_valid !== want.read_valid ||
                got.read_data !== want.read_data || got.read_index !== want.read_index ||
                got.need_write_data !== want.need_write_data ||
                got.done_res !== want.done_res) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %0d mismatch", checked);
                    $display("  expected %s", pins_text(want));
                    $display("  actual   %s", pins_text(got));
                end
            end
        endfunction
    endclass

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    srbm_pkg::t_in  i_data  = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    srbm_pkg::t_out o_data;

    burst_tracker tracker = new();

    // shared between sender and receiver
    bit calm        = 1'b0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    spi_register_burst_master uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // about one cycle in six idles, except during the calm stretch
    function automatic bit gap_now();
        return !calm && ($urandom_range(0, 99) < 17);
    endfunction

    // fully random item, every bit of every field free
    function automatic srbm_pkg::t_in rand_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(srbm_pkg::t_in)-1:0];
    endfunction

    // random item with a chosen operation
    function automatic srbm_pkg::t_in shaped(srbm_pkg::t_op op);
        srbm_pkg::t_in it;
        it = rand_item();
        it.operation = op;
        return it;
    endfunction

    // burst length: mostly short, sometimes zero, now and then longer
    function automatic logic [7:0] burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 85) return 8'($urandom_range(1, 4));
        if (r < 97) return 8'($urandom_range(5, 12));
        return 8'($urandom_range(13, 40));
    endfunction

    // receiver side: check accepted results, then pick the next stall level
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tracker.check_pins(o_data);
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= gap_now();
        end
    end

    // offer one item, with random idle cycles before it, and wait for acceptance
    task automatic send(input srbm_pkg::t_in it);
        while (gap_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_item(it);
    endtask

    // sender pauses until every queued pin state has been seen
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        srbm_pkg::t_in it;
        int  pick;
        int  sent;
        bit  held;
        bit  paused;

        held   = 1'b0;
        paused = 1'b0;
        sent   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle master: tick, push and the unused code change nothing
        it = shaped(srbm_pkg::OP_TICK);
        it.miso = 1'b1;
        send(it);
        it = shaped(srbm_pkg::OP_PUSH);
        it.write_byte = 8'hFF;
        send(it);
        it = '1;
        send(it);
        // read with zero count stays idle
        it = shaped(srbm_pkg::OP_START);
        it.is_read    = 1'b1;
        it.byte_count = 8'd0;
        send(it);

        // single-byte read at the top address, only the msb merged in
        it = '0;
        it.operation  = srbm_pkg::OP_START;
        it.is_read    = 1'b1;
        it.reg_addr   = 6'h3F;
        it.byte_count = 8'd1;
        it.rx_align   = 3'd7;
        it.old_first  = 8'hFF;
        send(it);
        for (int i = 0; i < 16; i++) begin
            // a second start while busy, and a push in read mode, are both ignored
            if (i == 4) send('0);
            if (i == 9) send(shaped(srbm_pkg::OP_PUSH));
            it = shaped(srbm_pkg::OP_TICK);
            send(it);
        end
        drain();

        // random part: mostly well-formed bursts with noise and broken sequences
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            it = shaped(srbm_pkg::OP_TICK);
            if (pick < 5) begin
                it = rand_item();
                if (it.operation == srbm_pkg::OP_START && !tracker.active)
                    it.byte_count = burst_len();
            end else if (!tracker.active) begin
                if (pick < 12) begin
                    it = shaped(srbm_pkg::t_op'($urandom_range(1, 3)));
                end else begin
                    it = shaped(srbm_pkg::OP_START);
                    it.byte_count = burst_len();
                end
            end else if (tracker.wants_byte()) begin
                // tick while waiting for data is ignored, as is a start
                if (pick < 12) it = shaped(pick < 9 ? srbm_pkg::OP_TICK :
                    (pick < 11 ? srbm_pkg::OP_NONE : srbm_pkg::OP_START));
                else it = shaped(srbm_pkg::OP_PUSH);
            end else if (pick < 12) begin
                // push while a byte is loaded and start while busy: both ignored
                it = shaped(pick < 8 ? srbm_pkg::OP_PUSH :
                    (pick < 10 ? srbm_pkg::OP_START : srbm_pkg::OP_NONE));
            end

            // long receiver hold-off while the sender keeps going
            if (!held && sent >= 400) begin
                held = 1'b1;
                hold_asked++;
            end
            calm = (sent >= 550) && (sent < 750);
            // sender pause until everything has come back
            if (!paused && sent >= 800) begin
                paused = 1'b1;
                drain();
            end
            send(it);
            sent++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        tracker.errors += tracker.pending();

        $display("%0d results checked, %0d items with effect, %0d bursts ended, %0d bytes read",
            tracker.checked, tracker.live_items, tracker.bursts_done, tracker.bytes_read);
        $display("covered read and write bursts, zero and single-byte counts, ignored items");
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors", tracker.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
